@@ sv/sitdt_pkg.sv @@
// ----------------------------------------------------------------------------
// sitdt_pkg: shared types and constants
// Widths, character codes, state encoding and the cell control group of the
// signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitdt_pkg;

  localparam int ValueW   = 32;
  localparam int CharW    = 8;
  localparam int DigitW   = 4;
  localparam int NumDigits = 10;
  localparam int BitCntW  = $clog2(ValueW);
  localparam int IdxW     = $clog2(NumDigits);

  localparam logic [CharW-1:0]  CharZero  = 8'h30;
  localparam logic [CharW-1:0]  CharMinus = 8'h2D;
  localparam logic [DigitW-1:0] AdjThresh = 4'd5;
  localparam logic [DigitW-1:0] AdjAdd    = 4'd3;
  localparam logic [DigitW-1:0] DigitMax  = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEAD,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ sv/sitdt_if.sv @@
// ----------------------------------------------------------------------------
// sitdt_if: stream channels
// Valid/ready channels for the input integer and the output characters.
// ----------------------------------------------------------------------------
interface sitdt_in_if
  import sitdt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitdt_out_if
  import sitdt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             final_char;

  modport source (output valid, output character, output final_char, input ready);
  modport sink   (input valid, input character, input final_char, output ready);
endinterface

@@ sv/sitdt_cell.sv @@
// ----------------------------------------------------------------------------
// sitdt_cell: one decimal digit of the shift-and-add-3 chain
// Holds one BCD digit, corrects it when it is five or more, shifts in the bit
// from its lower neighbor and hands its top bit to the upper neighbor.
// ----------------------------------------------------------------------------
module sitdt_cell
  import sitdt_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              bit_in,
  output logic              bit_out,
  output logic [DigitW-1:0] digit
);

  logic [DigitW-1:0] digit_r;
  logic [DigitW-1:0] digit_nxt;
  logic [DigitW-1:0] adj;

  always_comb begin
    adj = (digit_r >= AdjThresh) ? digit_r + AdjAdd : digit_r;
    bit_out = adj[DigitW-1];
    digit_nxt = digit_r;
    if (ctrl.clr) begin
      digit_nxt = '0;
    end else if (ctrl.shift) begin
      digit_nxt = {adj[DigitW-2:0], bit_in};
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

@@ sv/signed_int_to_decimal_text.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text: signed 32-bit integer to decimal ASCII text
// Conversion shifts one bit a cycle through the row of ten digit cells, a
// lead step then finds the leading digit, and one character per cycle follows
// while the output is not stalled. Each integer gives 1..11 output characters;
// a new integer is taken only once the last character of the previous one is
// loaded. Reset clears the controller and the output valid flag; cells need none.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text
  import sitdt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  sitdt_in_if.sink     in_chan,
  sitdt_out_if.source  out_chan
);

  state_t              state_r, state_nxt;
  logic [ValueW-1:0]   mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic [BitCntW-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [IdxW-1:0]     idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CharW-1:0]    out_char_r, out_char_nxt;
  logic                out_final_r, out_final_nxt;

  cell_ctrl_t          ctrl;
  logic [NumDigits:0]  carry;
  logic [DigitW-1:0]   digits [NumDigits];
  logic [IdxW-1:0]     lead;
  logic                bcd_ok;
  logic                in_beat;
  logic                out_free;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_beat = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign ctrl.clr = in_beat;
  assign ctrl.shift = (state_r == ST_CONV);
  assign carry[0] = mag_r[ValueW-1];

  for (genvar g = 0; g < NumDigits; g++) begin : g_cell
    sitdt_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .bit_in  (carry[g]),
      .bit_out (carry[g+1]),
      .digit   (digits[g])
    );
  end

  always_comb begin
    lead = '0;
    bcd_ok = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      if (digits[i] != '0) begin
        lead = IdxW'(i);
      end
      if (digits[i] > DigitMax) begin
        bcd_ok = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    bit_cnt_nxt = bit_cnt_r;
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_char_nxt = out_char_r;
    out_final_nxt = out_final_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          neg_nxt = in_chan.value[ValueW-1];
          mag_nxt = in_chan.value[ValueW-1] ? ~in_chan.value + 1'b1 : in_chan.value;
          bit_cnt_nxt = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        mag_nxt = {mag_r[ValueW-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BitCntW'(ValueW - 1)) begin
          state_nxt = ST_LEAD;
        end
      end
      ST_LEAD: begin
        idx_nxt = lead;
        state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt = CharMinus;
          out_final_nxt = 1'b0;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt = CharZero + CharW'(digits[idx_r]);
          out_final_nxt = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    idx_r <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_final_r <= out_final_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.character = out_char_r;
  assign out_chan.final_char = out_final_r;

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == ST_CONV) && (bit_cnt_r == '0))
    else $error("accepted beat did not start a conversion");

  a_no_chain_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> !carry[NumDigits])
    else $error("digit chain overflowed its top cell");

  a_digits_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEAD) |-> bcd_ok)
    else $error("digit cell holds a value above nine");

  a_minus_not_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == CharMinus) |-> !out_final_r)
    else $error("minus sign marked as last character");

  a_stalled_index_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT && out_valid_r && !out_chan.ready) |=> $stable(idx_r))
    else $error("digit index moved while output stalled");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: signed integer to decimal text converter
// Streams signed 32-bit integers into the converter and checks every output
// character and its last-character flag against a built-in decimal speller.
// Covers the range extremes, every text length, both signs and zero, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;
  import sitdt_pkg::*;

  localparam int Radix = 10;
  localparam int MaxGap = 17;
  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 80;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } text_beat_t;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   error_count;
  bit   src_calm;
  bit   sink_calm;
  bit   steady_flow;

  text_beat_t expected_chars[$];

  sitdt_in_if  in_bus ();
  sitdt_out_if out_bus ();

  signed_int_to_decimal_text dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic int draw_gap(input bit calm);
    if (calm || steady_flow) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  function automatic void spell_decimal(input logic [ValueW-1:0] raw);
    logic [ValueW-1:0] mag;
    logic [CharW-1:0]  digits[NumDigits];
    int                ndig;
    mag = raw[ValueW-1] ? (~raw + 1'b1) : raw;
    ndig = 0;
    do begin
      digits[ndig] = CharZero + CharW'(mag % Radix);
      ndig++;
      mag = mag / Radix;
    end while (mag != 0 && ndig < NumDigits);
    if (raw[ValueW-1]) expected_chars.push_back('{CharMinus, 1'b0});
    for (int i = ndig - 1; i >= 0; i--) begin
      expected_chars.push_back('{digits[i], i == 0});
    end
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= MaxReports) $display("ERROR at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic send_value(input logic signed [ValueW-1:0] v);
    int gap;
    if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= v;
    do @(posedge clk); while (!in_bus.ready);
    spell_decimal(v);
    @(negedge clk);
  endtask

  // The output side may stall for a random gap before each beat.
  initial begin : result_checker
    int         gap;
    text_beat_t want;
    forever begin
      if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
      gap = draw_gap(sink_calm);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_bus.valid));
      if (expected_chars.size() == 0) begin
        flag_error($sformatf("unexpected character 0x%02h last %0b",
                             out_bus.character, out_bus.final_char));
      end else begin
        want = expected_chars.pop_front();
        if (out_bus.character !== want.code || out_bus.final_char !== want.last) begin
          flag_error($sformatf("expected char 0x%02h last %0b, got char 0x%02h last %0b",
                               want.code, want.last, out_bus.character, out_bus.final_char));
        end
      end
      @(negedge clk);
    end
  end

  task automatic test_directed_extremes();
    send_value(32'sd0);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(32'sd9);
    send_value(-32'sd9);
    send_value(32'sd10);
    send_value(-32'sd10);
    send_value(32'sd99);
    send_value(32'sd100);
    send_value(32'sd999999999);
    send_value(32'sd1000000000);
    send_value(-32'sd999999999);
    send_value(-32'sd1000000000);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(32'sh8000_0001);
    send_value(32'sh5555_5555);
    send_value(32'shAAAA_AAAA);
  endtask

  task automatic test_digit_lengths(input int count);
    int     ndig;
    longint lo;
    longint hi;
    longint mag;
    repeat (count) begin
      ndig = $urandom_range(1, NumDigits);
      lo = (ndig == 1) ? 0 : 1;
      hi = 1;
      for (int i = 1; i < ndig; i++) lo = lo * Radix;
      for (int i = 0; i < ndig; i++) hi = hi * Radix;
      hi = hi - 1;
      if (hi > 64'sd2147483648) hi = 64'sd2147483648;
      mag = lo + longint'($urandom) % (hi - lo + 1);
      if ($urandom_range(0, 1) == 1) begin
        send_value(ValueW'(-mag));
      end else begin
        if (mag > 64'sd2147483647) mag = 64'sd2147483647;
        send_value(ValueW'(mag));
      end
    end
  endtask

  task automatic test_full_range(input int count);
    repeat (count) send_value($urandom);
  endtask

  task automatic test_back_to_back(input int count);
    steady_flow = 1'b1;
    test_digit_lengths(count);
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.value  <= '0;
    cycle_count   = 0;
    error_count   = 0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    steady_flow   = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_extremes();
    test_digit_lengths(200);
    test_full_range(180);
    test_back_to_back(80);

    in_bus.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/sitdt_pkg.sv
sv/sitdt_if.sv
sv/sitdt_cell.sv
sv/signed_int_to_decimal_text.sv
dv/testbench.sv
